// File: design/palette_pen_mapper_assert.svh
// Assertion macros for the palette pen mapper.
// Used by the top level only; expects a signal named clock and one named reset.
`ifndef PALETTE_PEN_MAPPER_ASSERT_SVH
`define PALETTE_PEN_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define PPM_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("palette_pen_mapper: check failed");

// Next-cycle implication.
`define PPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("palette_pen_mapper: check failed");

`endif

// File: design/ppm_pkg.sv
// Shared types, constants and the dominance function of the palette pen mapper.
// No dependencies.
`default_nettype none

package ppm_pkg;

   localparam int PaletteEntriesDefault = 32;
   localparam int CacheDepthDefault     = 256;

   // ceil(2^24 / 11): exact floor division by 11 for sums below 2^20
   localparam logic [20:0] RecipEleven = 21'd1525202;
   localparam int          RecipShift  = 24;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_MAP   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      CSR_MATCH_MODE = 1'd0,
      CSR_OPTIMIZE   = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_NEAR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [4:0]  palette_index;
      logic [11:0] palette_word;
      logic [7:0]  source_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } req_type;

   typedef struct packed {
      logic [7:0] pen;
      logic       cache_hit;
      logic [8:0] unique_count;
   } rsp_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [2:0]  dom;
      logic [7:0]  best;
      logic [15:0] best_dist;
      logic        found;
   } token_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  idx;
      logic [11:0] word;
   } pal_wr_type;

   // Returns {red, green, blue} dominance flags
   function automatic logic [2:0] dom3(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
      logic [9:0]  tot;
      logic [11:0] r10, g10, b10, r13, g13, b13;
      logic [10:0] r5, g5, b5;
      logic [2:0]  res;
      tot = 10'(r) + 10'(g) + 10'(b);
      r10 = 12'(r) * 12'd10;
      g10 = 12'(g) * 12'd10;
      b10 = 12'(b) * 12'd10;
      r13 = 12'(r) * 12'd13;
      g13 = 12'(g) * 12'd13;
      b13 = 12'(b) * 12'd13;
      r5  = 11'(r) * 11'd5;
      g5  = 11'(g) * 11'd5;
      b5  = 11'(b) * 11'd5;
      // c > tot/5 is the same as 5c > tot
      res[2] = (r10 > g13) && (r10 > b13) && (r5 > 11'(tot));
      res[1] = (g10 > r13) && (g10 > b13) && (g5 > 11'(tot));
      res[0] = (b10 > r13) && (b10 > g13) && (b5 > 11'(tot));
      if (tot < 10'd30) begin
         res = 3'b000;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/ppm_cell.sv
// One palette cell: holds one entry and scores the passing search token in two stages.
// Depends on ppm_pkg.
`default_nettype none

module ppm_cell
   import ppm_pkg::*;
#(
   parameter int CellIdx = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire pal_wr_type pal_wr,
   input  wire token_type  tok_i,
   output token_type       tok_o
);

   logic [11:0] word_ff;
   logic [2:0]  pdom_ff;
   token_type   a_tok_ff, a_tok_in, b_tok_ff, b_tok_in;
   logic [19:0] a_ws_ff, a_ws_in;
   logic        a_skip_ff, a_skip_in;

   logic [7:0]  pr, pg, pb, ar, ag, ab;
   logic [15:0] sr, sg, sb, q;
   logic [40:0] prod;

   always_ff @(posedge clock) begin
      if (pal_wr.en && pal_wr.idx == 8'(CellIdx)) begin
         word_ff <= pal_wr.word;
         pdom_ff <= dom3({pal_wr.word[11:8], pal_wr.word[11:8]},
                         {pal_wr.word[7:4], pal_wr.word[7:4]},
                         {pal_wr.word[3:0], pal_wr.word[3:0]});
      end
   end

   // Stage A: weighted squared distance and the dominance filter
   always_comb begin
      pr = {word_ff[11:8], word_ff[11:8]};
      pg = {word_ff[7:4], word_ff[7:4]};
      pb = {word_ff[3:0], word_ff[3:0]};
      ar = (tok_i.red > pr) ? tok_i.red - pr : pr - tok_i.red;
      ag = (tok_i.green > pg) ? tok_i.green - pg : pg - tok_i.green;
      ab = (tok_i.blue > pb) ? tok_i.blue - pb : pb - tok_i.blue;
      sr = 16'(ar) * 16'(ar);
      sg = 16'(ag) * 16'(ag);
      sb = 16'(ab) * 16'(ab);
      a_ws_in = 20'(sr) * 20'd3 + 20'(sg) * 20'd6 + 20'(sb) * 20'd2;
      a_skip_in = (tok_i.dom[1] && !pdom_ff[1]) || (tok_i.dom[2] && !pdom_ff[2]) ||
                  (tok_i.dom[0] && !pdom_ff[0]);
      a_tok_in = tok_i;
   end

   // Stage B: divide by 11 and keep the lowest index on ties
   always_comb begin
      prod = 41'(a_ws_ff) * 41'(RecipEleven);
      q = 16'(prod >> RecipShift);
      b_tok_in = a_tok_ff;
      if (!a_skip_ff && (!a_tok_ff.found || q < a_tok_ff.best_dist)) begin
         b_tok_in.best      = 8'(CellIdx);
         b_tok_in.best_dist = q;
         b_tok_in.found     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tok_ff <= '0;
         b_tok_ff <= '0;
      end else begin
         a_tok_ff <= a_tok_in;
         b_tok_ff <= b_tok_in;
      end
      a_ws_ff   <= a_ws_in;
      a_skip_ff <= a_skip_in;
   end

   assign tok_o = b_tok_ff;

endmodule

`default_nettype wire

// File: design/palette_pen_mapper.sv
// Palette pen mapper top level: request control, duplicate cache and the cell row.
// Depends on ppm_pkg, ppm_cell and palette_pen_mapper_assert.svh.
`default_nettype none

// Maps source colors to pens, one request at a time. A palette load or a new-mapping
// request is taken in the idle state and gives no result. A map request passes from
// idle through the miss state to the output state (straight to the output state for
// source index zero in sequential mode). With duplicate reuse on, a scan state first
// examines the cache entries (one cache read per cycle) and goes to the miss state when
// no entry matches. In nearest mode the miss state then sends the search token through
// the row of palette cells at two stages per cell. The result is held until taken; the
// next request is accepted after that. No clearing pass follows reset.

module palette_pen_mapper
   import ppm_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PaletteEntriesDefault,
   parameter int CACHE_DEPTH     = CacheDepthDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_index,
   input  wire logic    csr_wdata
);

   localparam int FILL_W = $clog2(CACHE_DEPTH + 1);
   localparam int CA_W   = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

   state_type         state_ff, state_in;
   logic              mm_ff, opt_ff;
   logic [23:0]       rgb_ff, rgb_in;
   logic [7:0]        sidx_ff, sidx_in;
   logic [FILL_W-1:0] fill_ff, fill_in, scan_ff, scan_in;
   logic [7:0]        nfp_ff, nfp_in, pen_ff, pen_in;
   logic              hit_ff, hit_in, pend_ff, pend_in, inject_ff, inject_in;
   logic [31:0]       rd_q_ff;
   logic [31:0]       cache_mem [CACHE_DEPTH];
   logic              wr_en, full, accept;
   logic [31:0]       wr_data;
   pal_wr_type        pal_wr;
   token_type         tok [PALETTE_ENTRIES+1];

   assign accept = req_valid && req_ready;
   assign full   = (fill_ff == FILL_W'(CACHE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff  <= 1'b0;
         opt_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MATCH_MODE: mm_ff  <= csr_wdata;
            CSR_OPTIMIZE:   opt_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      pal_wr.en   = accept && (mode_type'(req_data.mode) == MODE_LOAD) &&
                    (9'(req_data.palette_index) < 9'(PALETTE_ENTRIES));
      pal_wr.idx  = 8'(req_data.palette_index);
      pal_wr.word = req_data.palette_word;
   end

   always_comb begin
      state_in  = state_ff;
      rgb_in    = rgb_ff;
      sidx_in   = sidx_ff;
      fill_in   = fill_ff;
      scan_in   = scan_ff;
      nfp_in    = nfp_ff;
      pen_in    = pen_ff;
      hit_in    = hit_ff;
      pend_in   = 1'b0;
      inject_in = 1'b0;
      wr_en     = 1'b0;
      wr_data   = {rgb_ff, pen_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (mode_type'(req_data.mode))
                  MODE_LOAD: begin
                  end
                  MODE_CLEAR: begin
                     fill_in = '0;
                     nfp_in  = 8'd2;
                  end
                  MODE_MAP: begin
                     rgb_in  = {req_data.red, req_data.green, req_data.blue};
                     sidx_in = req_data.source_index;
                     hit_in  = 1'b0;
                     if (mm_ff && req_data.source_index == 8'd0) begin
                        pen_in   = 8'd1;
                        wr_data  = {req_data.red, req_data.green, req_data.blue, 8'd1};
                        wr_en    = !full;
                        state_in = ST_OUT;
                     end else if (opt_ff) begin
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_MISS;
                     end
                  end
                  MODE_NONE: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (pend_ff && rd_q_ff[31:8] == rgb_ff) begin
               pen_in   = rd_q_ff[7:0];
               hit_in   = 1'b1;
               state_in = ST_OUT;
            end else if (scan_ff < fill_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            if (!mm_ff) begin
               inject_in = 1'b1;
               state_in  = ST_NEAR;
            end else if (!full) begin
               pen_in  = nfp_ff;
               wr_data = {rgb_ff, nfp_ff};
               wr_en   = 1'b1;
               if (nfp_ff != 8'd255) begin
                  nfp_in = nfp_ff + 1'b1;
               end
               state_in = ST_OUT;
            end else begin
               pen_in   = (sidx_ff == 8'd255) ? 8'd255 : sidx_ff + 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_NEAR: begin
            if (tok[PALETTE_ENTRIES].valid) begin
               pen_in = (tok[PALETTE_ENTRIES].best == 8'd255) ? 8'd255 :
                        tok[PALETTE_ENTRIES].best + 1'b1;
               wr_data  = {rgb_ff, pen_in};
               wr_en    = opt_ff && !full;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (wr_en) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         nfp_ff    <= 8'd2;
         pend_ff   <= 1'b0;
         inject_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         nfp_ff    <= nfp_in;
         pend_ff   <= pend_in;
         inject_ff <= inject_in;
      end
      rgb_ff  <= rgb_in;
      sidx_ff <= sidx_in;
      scan_ff <= scan_in;
      pen_ff  <= pen_in;
      hit_ff  <= hit_in;
   end

   // Duplicate cache: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cache_mem[fill_ff[CA_W-1:0]] <= wr_data;
      end
      rd_q_ff <= cache_mem[scan_ff[CA_W-1:0]];
   end

   always_comb begin
      tok[0].valid     = inject_ff;
      tok[0].red       = rgb_ff[23:16];
      tok[0].green     = rgb_ff[15:8];
      tok[0].blue      = rgb_ff[7:0];
      tok[0].dom       = dom3(rgb_ff[23:16], rgb_ff[15:8], rgb_ff[7:0]);
      tok[0].best      = 8'd1;
      tok[0].best_dist = '0;
      tok[0].found     = 1'b0;
   end

   for (genvar j = 0; j < PALETTE_ENTRIES; j++) begin : g_cell
      ppm_cell #(
         .CellIdx(j)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .pal_wr(pal_wr),
         .tok_i (tok[j]),
         .tok_o (tok[j+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   always_comb begin
      rsp_data.pen          = pen_ff;
      rsp_data.cache_hit    = hit_ff;
      rsp_data.unique_count = 9'(fill_ff);
   end

`include "palette_pen_mapper_assert.svh"

   `PPM_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_ff <= FILL_W'(CACHE_DEPTH))
   `PPM_ASSERT_IMPLIES(a_token_in_search, tok[PALETTE_ENTRIES].valid, state_ff == ST_NEAR)
   `PPM_ASSERT_NEXT(a_hit_from_scan, state_ff == ST_SCAN && state_in == ST_OUT,
                    rsp_data.cache_hit)

endmodule

`default_nettype wire

// File: tb/tb_palette_pen_mapper.sv
// Self-checking testbench for the palette pen mapper: palette loads, nearest and
// sequential mapping, duplicate cache reuse. Depends on ppm_pkg and palette_pen_mapper.
`default_nettype none

module tb_palette_pen_mapper
   import ppm_pkg::*;
;

   localparam int NumPal    = 32;
   localparam int CacheSize = 256;
   localparam int IdleLimit = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = 1'b0;
   logic    csr_wdata = 1'b0;

   palette_pen_mapper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [11:0] pal_words [NumPal];
   logic [23:0] seen_colors [CacheSize];
   logic [7:0]  seen_pens [CacheSize];
   int          seen_fill;
   int          free_pen;
   logic        seq_mode;
   logic        reuse_on;

   rsp_type expected_pens [$];
   int      mismatches;
   int      idle_cycles;
   bit      hold_off;
   int      stall_len;

   function automatic logic [2:0] dominance(int r, int g, int b);
      int t;
      logic [2:0] d;
      t = r + g + b;
      d[2] = (r * 10 > g * 13) && (r * 10 > b * 13) && (r > t / 5);
      d[1] = (g * 10 > r * 13) && (g * 10 > b * 13) && (g > t / 5);
      d[0] = (b * 10 > r * 13) && (b * 10 > g * 13) && (b > t / 5);
      if (t < 30) d = 3'b000;
      return d;
   endfunction

   function automatic int nearest_entry(int r, int g, int b);
      logic [2:0] src, ent;
      int pr, pg, pb, score, best, bestd;
      // with no passing entry the pen comes out as 2
      best = 1;
      bestd = -1;
      src = dominance(r, g, b);
      for (int j = 0; j < NumPal; j++) begin
         pr = pal_words[j][11:8] * 17;
         pg = pal_words[j][7:4] * 17;
         pb = pal_words[j][3:0] * 17;
         ent = dominance(pr, pg, pb);
         if ((src & ~ent) != 3'b000) continue;
         score = (3 * (r - pr) * (r - pr) + 6 * (g - pg) * (g - pg)
                  + 2 * (b - pb) * (b - pb)) / 11;
         if (bestd < 0 || score < bestd) begin
            bestd = score;
            best = j;
         end
      end
      return best + 1;
   endfunction

   function automatic void remember(logic [23:0] rgb, int pen);
      if (seen_fill < CacheSize) begin
         seen_colors[seen_fill] = rgb;
         seen_pens[seen_fill] = pen[7:0];
         seen_fill++;
      end
   endfunction

   function automatic void predict_pen(req_type it);
      logic [23:0] rgb;
      int pen;
      bit hit;
      rsp_type e;
      rgb = {it.red, it.green, it.blue};
      pen = 0;
      hit = 0;
      if (it.mode == MODE_LOAD) begin
         pal_words[it.palette_index] = it.palette_word;
         return;
      end
      if (it.mode == MODE_CLEAR) begin
         seen_fill = 0;
         free_pen = 2;
         return;
      end
      if (it.mode != MODE_MAP) return;
      if (seq_mode && it.source_index == 0) begin
         pen = 1;
         remember(rgb, 1);
      end else begin
         if (reuse_on)
            for (int j = 0; j < seen_fill; j++)
               if (!hit && seen_colors[j] == rgb) begin
                  pen = seen_pens[j];
                  hit = 1;
               end
         if (!hit) begin
            if (!seq_mode) begin
               pen = nearest_entry(it.red, it.green, it.blue);
               if (reuse_on) remember(rgb, pen);
            end else if (seen_fill < CacheSize) begin
               pen = free_pen;
               remember(rgb, pen);
               if (free_pen < 255) free_pen++;
            end else begin
               pen = it.source_index + 1;
               if (pen > 255) pen = 255;
            end
         end
      end
      e.pen = pen[7:0];
      e.cache_hit = hit;
      e.unique_count = seen_fill[8:0];
      expected_pens.push_back(e);
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IdleLimit) begin
            $display("tb_palette_pen_mapper: done, errors");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result pen=%0d", rsp_data.pen);
            end else begin
               rsp_type e;
               e = expected_pens.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp pen=%0d hit=%0d cnt=%0d, got pen=%0d hit=%0d cnt=%0d",
                              e.pen, e.cache_hit, e.unique_count,
                              rsp_data.pen, rsp_data.cache_hit, rsp_data.unique_count);
               end
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (stall_len > 0) begin
         stall_len <= stall_len - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_len <= $urandom_range(1, 40);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   int burst_left;

   // valid stays up between items of a burst; drop it only in a gap or a drain
   task automatic send_item(req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pen(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pens.size() != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MATCH_MODE) seq_mode = val;
      else reuse_on = val;
   endtask

   function automatic req_type make_map(logic [7:0] si, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
      req_type it;
      it = '0;
      it.mode = MODE_MAP;
      it.source_index = si;
      it.red = r;
      it.green = g;
      it.blue = b;
      return it;
   endfunction

   function automatic req_type make_load(int idx, logic [11:0] w);
      req_type it;
      it = '0;
      it.mode = MODE_LOAD;
      it.palette_index = idx[4:0];
      it.palette_word = w;
      return it;
   endfunction

   function automatic req_type random_map(bit few_colors);
      req_type it;
      it = make_map(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      // a small color set gives plenty of repeats for the cache
      if (few_colors) begin
         it.red = 8'($urandom_range(0, 3) * 85);
         it.green = 8'($urandom_range(0, 1) * 255);
         it.blue = 8'($urandom_range(0, 1) * 200);
      end
      it.palette_index = 5'($urandom);
      it.palette_word = 12'($urandom);
      return it;
   endfunction

   task automatic load_palette();
      for (int j = 0; j < NumPal; j++) send_item(make_load(j, 12'($urandom_range(0, 4095))));
   endtask

   task automatic test_directed();
      req_type it;
      load_palette();
      send_item(make_load(0, 12'h000));
      send_item(make_load(1, 12'hFFF));
      send_item(make_load(2, 12'hF00));
      send_item(make_load(3, 12'h0F0));
      send_item(make_load(4, 12'h00F));
      send_item(make_map(0, 8'd0, 8'd0, 8'd0));
      send_item(make_map(255, 8'd255, 8'd255, 8'd255));
      send_item(make_map(7, 8'd250, 8'd10, 8'd10));
      send_item(make_map(8, 8'd10, 8'd250, 8'd10));
      send_item(make_map(9, 8'd10, 8'd10, 8'd250));
      send_item(make_map(9, 8'd9, 8'd9, 8'd9));
      // duplicate palette entries: lowest index must win the tie
      send_item(make_load(5, 12'hFFF));
      send_item(make_map(1, 8'd255, 8'd255, 8'd255));
      it = make_map(3, 8'd1, 8'd2, 8'd3);
      it.mode = MODE_NONE;
      send_item(it);
      it.mode = MODE_CLEAR;
      send_item(it);
      drain();
   endtask

   task automatic test_no_passing_entry();
      // all-gray palette: dominant sources find no entry and get pen 2
      for (int j = 0; j < NumPal; j++) send_item(make_load(j, 12'h777));
      send_item(make_map(4, 8'd255, 8'd0, 8'd0));
      send_item(make_map(5, 8'd0, 8'd0, 8'd255));
      drain();
      load_palette();
      drain();
   endtask

   task automatic test_random_phase(logic seq, logic reuse, int count, bit few);
      req_type it;
      drain();
      write_csr(CSR_MATCH_MODE, seq);
      write_csr(CSR_OPTIMIZE, reuse);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 39))
            0: send_item(make_load($urandom_range(0, 31), 12'($urandom_range(0, 4095))));
            1: begin
               it = random_map(0);
               it.mode = MODE_CLEAR;
               send_item(it);
            end
            2: begin
               it = random_map(0);
               it.mode = MODE_NONE;
               send_item(it);
            end
            default: send_item(random_map(few));
         endcase
      end
   endtask

   task automatic test_cache_overflow();
      // fill past the cache depth in sequential mode
      drain();
      write_csr(CSR_MATCH_MODE, 1'b1);
      write_csr(CSR_OPTIMIZE, 1'b0);
      send_item(make_map(0, 8'd0, 8'd0, 8'd0));
      for (int n = 0; n < 300; n++) send_item(random_map(0));
      send_item(make_map(255, 8'd1, 8'd1, 8'd1));
   endtask

   task automatic test_backpressure();
      // hold the receiver off while requests keep coming
      hold_off = 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         for (int n = 0; n < 10; n++) send_item(random_map(1));
      join
      drain();
   endtask

   initial begin
      idle_cycles = 0;
      mismatches = 0;
      burst_left = 0;
      hold_off = 0;
      stall_len = 0;
      seen_fill = 0;
      free_pen = 2;
      seq_mode = 0;
      reuse_on = 0;
      for (int j = 0; j < NumPal; j++) pal_words[j] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_no_passing_entry();
      test_random_phase(1'b0, 1'b1, 350, 1);
      test_random_phase(1'b0, 1'b0, 250, 0);
      test_random_phase(1'b1, 1'b1, 400, 1);
      test_random_phase(1'b1, 1'b0, 300, 0);
      test_cache_overflow();
      test_random_phase(1'b0, 1'b1, 300, 0);
      test_backpressure();
      drain();
      if (mismatches == 0 && expected_pens.size() == 0) begin
         $display("tb_palette_pen_mapper: done, clean");
      end else begin
         $display("tb_palette_pen_mapper: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/ppm_pkg.sv
design/ppm_cell.sv
design/palette_pen_mapper.sv
tb/tb_palette_pen_mapper.sv
